>>> hdl/erv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erv_pkg
// Shared types and constants of the event record validator.
// ----------------------------------------------------------------------------
package erv_pkg;

   // width of the per-record byte counter
   localparam int LENGTH_BITS = 16;

   typedef logic [LENGTH_BITS-1:0] count_type;

   typedef enum logic [7:0] {
      PH_TAG      = 8'b0000_0001,
      PH_TYPE     = 8'b0000_0010,
      PH_SKIP     = 8'b0000_0100,
      PH_STRLEN   = 8'b0000_1000,
      PH_COUNT    = 8'b0001_0000,
      PH_ITEMTYPE = 8'b0010_0000,
      PH_DONE     = 8'b0100_0000,
      PH_ERROR    = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      ERR_OK     = 3'd0,
      ERR_LENGTH = 3'd1,
      ERR_TRUNC  = 3'd2,
      ERR_TYPE   = 3'd3,
      ERR_ITEM   = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      CSR_INT_CODE    = 2'd0,
      CSR_LONG_CODE   = 2'd1,
      CSR_STRING_CODE = 2'd2,
      CSR_LIST_CODE   = 2'd3
   } csr_index_type;

   localparam logic [31:0] INT_BYTES  = 32'd4;
   localparam logic [31:0] LONG_BYTES = 32'd8;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] declared_length;
   } req_payload_type;

   typedef struct packed {
      logic        record_ok;
      logic [2:0]  error_code;
      logic [31:0] error_total;
   } rsp_payload_type;

endpackage
`default_nettype wire

>>> hdl/event_record_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// event_record_validator
// Parses tag/type/body event records one byte per beat and reports one
// verdict per record with a saturating failure count.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_ready   | req_payload (byte, first, last, length)
//  rsp     | out | rsp_valid/rsp_ready   | rsp_payload (ok, code, total)
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// One byte per cycle unless a last byte is held: an input register feeds the
// parse update and the result register, and rsp_valid is set as a last byte
// leaves the input register. Synchronous reset clears parse state and the
// failure count and restores the default type codes. A last byte waits in the
// input register while the result register is full and not taken; req_ready
// stays low until it moves on. csr writes are always accepted.
// ----------------------------------------------------------------------------
module event_record_validator (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  erv_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output erv_pkg::rsp_payload_type  rsp_payload,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  erv_pkg::csr_index_type    csr_index,
   input  wire  [7:0]                csr_data
);

   // input register
   logic                      in_valid_ff;
   erv_pkg::req_payload_type  in_pl_ff;
   logic                      in_advance;

   // type codes
   logic [7:0] int_code_ff, long_code_ff, string_code_ff, list_code_ff;

   // parse state
   erv_pkg::phase_type  phase_ff,  phase_in;
   logic [31:0]         skip_ff,   skip_in;
   logic [31:0]         lasm_ff,   lasm_in;
   logic [1:0]          lbi_ff,    lbi_in;
   logic [7:0]          items_ff,  items_in;
   logic                inlist_ff, inlist_in;
   erv_pkg::count_type  bytes_ff,  bytes_in;
   logic [15:0]         expect_ff, expect_in;
   erv_pkg::err_type    ferr_ff,   ferr_in;
   logic                over_ff,   over_in;
   logic [31:0]         errcnt_ff, errcnt_in;

   // result register
   logic                      rsp_valid_ff;
   erv_pkg::rsp_payload_type  rsp_pl_ff;
   erv_pkg::err_type          verdict;

   assign in_advance = in_valid_ff &&
                       (!in_pl_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || in_advance;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_pl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_pl_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_code_ff    <= 8'd0;
         long_code_ff   <= 8'd1;
         string_code_ff <= 8'd2;
         list_code_ff   <= 8'd3;
      end else if (csr_valid) begin
         case (csr_index)
            erv_pkg::CSR_INT_CODE:    int_code_ff    <= csr_data;
            erv_pkg::CSR_LONG_CODE:   long_code_ff   <= csr_data;
            erv_pkg::CSR_STRING_CODE: string_code_ff <= csr_data;
            erv_pkg::CSR_LIST_CODE:   list_code_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [7:0] b;
      b = in_pl_ff.data_byte;

      phase_in  = phase_ff;
      skip_in   = skip_ff;
      lasm_in   = lasm_ff;
      lbi_in    = lbi_ff;
      items_in  = items_ff;
      inlist_in = inlist_ff;
      bytes_in  = bytes_ff;
      expect_in = expect_ff;
      ferr_in   = ferr_ff;
      over_in   = over_ff;
      errcnt_in = errcnt_ff;
      verdict   = erv_pkg::ERR_OK;

      if (in_advance) begin
         if (in_pl_ff.first_byte) begin
            phase_in  = erv_pkg::PH_TAG;
            skip_in   = '0;
            lasm_in   = '0;
            lbi_in    = '0;
            items_in  = '0;
            inlist_in = 1'b0;
            bytes_in  = '0;
            expect_in = in_pl_ff.declared_length;
            ferr_in   = erv_pkg::ERR_OK;
            over_in   = 1'b0;
         end

         if (bytes_in != '1) begin
            bytes_in = bytes_in + erv_pkg::count_type'(1);
         end else begin
            over_in = 1'b1;
         end

         case (phase_in)
            erv_pkg::PH_TAG: begin
               if (lbi_in == 2'd3) begin
                  lbi_in   = '0;
                  phase_in = erv_pkg::PH_TYPE;
               end else begin
                  lbi_in = lbi_in + 2'd1;
               end
            end
            erv_pkg::PH_TYPE: begin
               if (b == int_code_ff) begin
                  skip_in  = erv_pkg::INT_BYTES;
                  phase_in = erv_pkg::PH_SKIP;
               end else if (b == long_code_ff) begin
                  skip_in  = erv_pkg::LONG_BYTES;
                  phase_in = erv_pkg::PH_SKIP;
               end else if (b == string_code_ff) begin
                  lasm_in  = '0;
                  lbi_in   = '0;
                  phase_in = erv_pkg::PH_STRLEN;
               end else if (b == list_code_ff) begin
                  phase_in = erv_pkg::PH_COUNT;
               end else begin
                  ferr_in  = erv_pkg::ERR_TYPE;
                  phase_in = erv_pkg::PH_ERROR;
               end
            end
            erv_pkg::PH_STRLEN: begin
               lasm_in = lasm_in | ({24'd0, b} << {lbi_in, 3'b000});
               if (lbi_in == 2'd3) begin
                  lbi_in  = '0;
                  skip_in = lasm_in;
                  if (lasm_in == '0) begin
                     phase_in = (inlist_in && items_in != '0) ?
                                erv_pkg::PH_ITEMTYPE : erv_pkg::PH_DONE;
                  end else begin
                     phase_in = erv_pkg::PH_SKIP;
                  end
               end else begin
                  lbi_in = lbi_in + 2'd1;
               end
            end
            erv_pkg::PH_COUNT: begin
               items_in  = b;
               inlist_in = 1'b1;
               phase_in  = (b == 8'd0) ? erv_pkg::PH_DONE : erv_pkg::PH_ITEMTYPE;
            end
            erv_pkg::PH_ITEMTYPE: begin
               if (items_in != '0) begin
                  items_in = items_in - 8'd1;
               end
               // string wins over int and long when codes coincide
               if (b == string_code_ff) begin
                  lasm_in  = '0;
                  lbi_in   = '0;
                  phase_in = erv_pkg::PH_STRLEN;
               end else if (b == int_code_ff) begin
                  skip_in  = erv_pkg::INT_BYTES;
                  phase_in = erv_pkg::PH_SKIP;
               end else if (b == long_code_ff) begin
                  skip_in  = erv_pkg::LONG_BYTES;
                  phase_in = erv_pkg::PH_SKIP;
               end else begin
                  ferr_in  = erv_pkg::ERR_ITEM;
                  phase_in = erv_pkg::PH_ERROR;
               end
            end
            erv_pkg::PH_SKIP: begin
               if (skip_in != '0) begin
                  skip_in = skip_in - 32'd1;
               end
               if (skip_in == '0) begin
                  phase_in = (inlist_in && items_in != '0) ?
                             erv_pkg::PH_ITEMTYPE : erv_pkg::PH_DONE;
               end
            end
            default: ;
         endcase

         if (in_pl_ff.last_byte) begin
            if (over_in || (32'(bytes_in) != 32'(expect_in))) begin
               verdict = erv_pkg::ERR_LENGTH;
            end else if (ferr_in != erv_pkg::ERR_OK) begin
               verdict = ferr_in;
            end else if (phase_in != erv_pkg::PH_DONE) begin
               verdict = erv_pkg::ERR_TRUNC;
            end else begin
               verdict = erv_pkg::ERR_OK;
            end

            if (verdict != erv_pkg::ERR_OK && errcnt_ff != '1) begin
               errcnt_in = errcnt_ff + 32'd1;
            end

            // next record starts with no declared length
            phase_in  = erv_pkg::PH_TAG;
            skip_in   = '0;
            lasm_in   = '0;
            lbi_in    = '0;
            items_in  = '0;
            inlist_in = 1'b0;
            bytes_in  = '0;
            expect_in = '0;
            ferr_in   = erv_pkg::ERR_OK;
            over_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= erv_pkg::PH_TAG;
         skip_ff   <= '0;
         lasm_ff   <= '0;
         lbi_ff    <= '0;
         items_ff  <= '0;
         inlist_ff <= 1'b0;
         bytes_ff  <= '0;
         expect_ff <= '0;
         ferr_ff   <= erv_pkg::ERR_OK;
         over_ff   <= 1'b0;
         errcnt_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         skip_ff   <= skip_in;
         lasm_ff   <= lasm_in;
         lbi_ff    <= lbi_in;
         items_ff  <= items_in;
         inlist_ff <= inlist_in;
         bytes_ff  <= bytes_in;
         expect_ff <= expect_in;
         ferr_ff   <= ferr_in;
         over_ff   <= over_in;
         errcnt_ff <= errcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_advance && in_pl_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (in_advance && in_pl_ff.last_byte) begin
         rsp_pl_ff.record_ok   <= (verdict == erv_pkg::ERR_OK);
         rsp_pl_ff.error_code  <= verdict;
         rsp_pl_ff.error_total <= errcnt_in;
      end
   end

   // verdict flag and code agree
   a_ok_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pl_ff.record_ok == (rsp_pl_ff.error_code == erv_pkg::ERR_OK)))
      else $error("record_ok disagrees with error_code");

   // failure count never goes down
   a_count_monotone: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (errcnt_ff >= $past(errcnt_ff)))
      else $error("error count decreased");

   // a processed last byte loads a result that holds the updated failure count
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_advance && in_pl_ff.last_byte) |=> (rsp_valid_ff &&
         rsp_pl_ff.error_total == errcnt_ff))
      else $error("result register not loaded on last byte");

endmodule
`default_nettype wire
